// ===== hw/rtl/spp_pkg.sv =====
// Shared types, constants and helper functions of the sweep-and-prune pair finder.
`timescale 1ns / 1ps

package spp_pkg;

	localparam int MAX_ENTRIES_DEF = 8;
	localparam logic [15:0] MARGIN_RESET = 16'd655;

	// One stored box after widening.
	typedef struct packed {
		logic [15:0]        group;
		logic               sleeping;
		logic               is_static;
		logic signed [31:0] max_z;
		logic signed [31:0] min_z;
		logic signed [31:0] max_y;
		logic signed [31:0] min_y;
		logic signed [31:0] max_x;
		logic signed [31:0] min_x;
		logic [15:0]        body;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CUR_RD,
		ST_CUR_CAP,
		ST_OTH_RD,
		ST_OTH_CMP,
		ST_FINISH
	} spp_state_t;

	// Lower a bound by the margin, clamped at the most negative value.
	function automatic logic signed [31:0] widen_low(logic signed [31:0] v, logic [15:0] m);
		logic signed [32:0] d;
		d = {v[31], v} - $signed({17'd0, m});
		return (d[32] != d[31]) ? 32'sh8000_0000 : d[31:0];
	endfunction

	// Raise a bound by the margin, clamped at the most positive value.
	function automatic logic signed [31:0] widen_high(logic signed [31:0] v, logic [15:0] m);
		logic signed [32:0] d;
		d = {v[31], v} + $signed({17'd0, m});
		return (d[32] != d[31]) ? 32'sh7FFF_FFFF : d[31:0];
	endfunction

	// True when the later entry cur and the earlier entry oth form a reported pair.
	function automatic logic pair_hit(box_t cur, box_t oth);
		logic ok;
		ok = (oth.max_x >= cur.min_x);
		ok = ok && (cur.body != oth.body);
		ok = ok && !(cur.is_static && oth.is_static);
		ok = ok && !(cur.sleeping && oth.sleeping);
		ok = ok && !((cur.group != 16'd0) && (cur.group == oth.group));
		ok = ok && !((cur.max_y < oth.min_y) || (cur.min_y > oth.max_y));
		ok = ok && !((cur.max_z < oth.min_z) || (cur.min_z > oth.max_z));
		return ok;
	endfunction

endpackage

// ===== hw/rtl/spp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module spp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/spp_sorter.sv =====
// Insertion sorter that keeps entry indexes ordered by min_x as boxes arrive.
`timescale 1ns / 1ps

module spp_sorter #(
	parameter int DEPTH = spp_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic [$clog2(DEPTH+1)-1:0] fill,
	input  logic                       insert,
	input  logic signed [31:0]         key,
	input  logic [$clog2(DEPTH)-1:0]   idx,
	input  logic [$clog2(DEPTH)-1:0]   rd_pos,
	output logic [$clog2(DEPTH)-1:0]   rd_idx
);

	localparam int IDXW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH+1);

	logic signed [31:0] key_q [DEPTH];
	logic [IDXW-1:0]    idx_q [DEPTH];
	logic [CNTW-1:0]    pos;

	// Equal keys land behind the ones already held, which keeps arrival order.
	always_comb begin
		pos = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if ((CNTW'(j) < fill) && (key_q[j] <= key)) begin
				pos = pos + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			for (int j = 0; j < DEPTH; j++) begin
				if (CNTW'(j) == pos) begin
					key_q[j] <= key;
					idx_q[j] <= idx;
				end else if ((j > 0) && (CNTW'(j) > pos)) begin
					key_q[j] <= key_q[(j > 0) ? j - 1 : 0];
					idx_q[j] <= idx_q[(j > 0) ? j - 1 : 0];
				end
			end
		end
	end

	assign rd_idx = idx_q[rd_pos];

endmodule

// ===== hw/rtl/sweep_prune_pair_finder_top.sv =====
// Top level of the sweep-and-prune pair finder: loading, sweep control and ports.
// A box that does not close the set is stored in its accept cycle. After the closing
// box the sweep reads each later entry in min_x order (CUR_RD, CUR_CAP), tests it against
// each earlier entry (OTH_RD, OTH_CMP) and ends in FINISH; a full output stalls the
// compare and FINISH steps, and reads of the box RAM set the pace.
// Throughput: one box per cycle while loading, no boxes are taken during the sweep.
// Reset (arst_n low, asynchronous) empties the set, clears the drop flag and the output
// valid flag and loads the margin with its default; box storage is not cleared.
`timescale 1ns / 1ps

module sweep_prune_pair_finder_top #(
	parameter int MAX_ENTRIES = spp_pkg::MAX_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Box requests.
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// body_id[15:0], min_x[47:16], max_x[79:48], min_y[111:80], max_y[143:112],
	// min_z[175:144], max_z[207:176], is_static[208], is_sleeping[209], group_id[225:210],
	// zero fill above.
	input  logic [231:0] s_axis_tdata,
	input  logic         s_axis_tlast,  // last_entry
	// Pair results.
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata,  // first_body[15:0], second_body[31:16]
	output logic [1:0]   m_axis_tuser,  // pair_valid[0], overflow[1]
	output logic         m_axis_tlast,  // last_pair
	// Margin register write.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	import spp_pkg::*;

	localparam int IDXW = $clog2(MAX_ENTRIES);
	localparam int CNTW = $clog2(MAX_ENTRIES+1);

	spp_state_t state_q, state_d;

	logic [15:0]     margin_q;
	logic [CNTW-1:0] count_q;
	logic            dropped_q;
	logic [IDXW-1:0] i_q, k_q;
	box_t            cur_q;

	// The newest pair found is held back, so that the final one can carry last_pair.
	logic            pend_valid_q;
	logic [15:0]     pend_first_q, pend_second_q;

	logic            out_valid_q, out_last_q, out_pair_q, out_ovf_q;
	logic [15:0]     out_first_q, out_second_q;

	box_t            in_box, rd_box;
	logic            in_take, store, out_free, hit, out_load;
	logic            ram_rd_en;
	logic [IDXW-1:0] sort_pos, sort_idx;
	logic [CNTW-1:0] count_new;
	logic [CNTW-1:0] k_next, i_next;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_axis_tready;

	// Widen the incoming box by the margin on the way into storage.
	always_comb begin
		in_box.body      = s_axis_tdata[15:0];
		in_box.min_x     = widen_low(s_axis_tdata[47:16], margin_q);
		in_box.max_x     = widen_high(s_axis_tdata[79:48], margin_q);
		in_box.min_y     = widen_low(s_axis_tdata[111:80], margin_q);
		in_box.max_y     = widen_high(s_axis_tdata[143:112], margin_q);
		in_box.min_z     = widen_low(s_axis_tdata[175:144], margin_q);
		in_box.max_z     = widen_high(s_axis_tdata[207:176], margin_q);
		in_box.is_static = s_axis_tdata[208];
		in_box.sleeping  = s_axis_tdata[209];
		in_box.group     = s_axis_tdata[225:210];
	end

	assign in_take   = s_axis_tvalid && s_axis_tready;
	// A box that finds the buffer full is dropped but may still close the set.
	assign store     = in_take && (count_q < CNTW'(MAX_ENTRIES));
	assign count_new = store ? count_q + CNTW'(1) : count_q;
	assign k_next    = CNTW'(k_q) + CNTW'(1);
	assign i_next    = CNTW'(i_q) + CNTW'(1);
	assign hit       = pair_hit(cur_q, rd_box);
	// The output register takes a new result when a held pair is released or the set closes.
	assign out_load  = ((state_q == ST_OTH_CMP) && hit && pend_valid_q && out_free)
		|| ((state_q == ST_FINISH) && out_free);

	spp_ram #(
		.WIDTH (BOX_W),
		.DEPTH (MAX_ENTRIES)
	) u_box_ram (
		.clk     (clk),
		.wr_en   (store),
		.wr_addr (count_q[IDXW-1:0]),
		.wr_data (in_box),
		.rd_en   (ram_rd_en),
		.rd_addr (sort_idx),
		.rd_data (rd_box)
	);

	spp_sorter #(
		.DEPTH (MAX_ENTRIES)
	) u_sorter (
		.clk    (clk),
		.fill   (count_q),
		.insert (store),
		.key    (in_box.min_x),
		.idx    (count_q[IDXW-1:0]),
		.rd_pos (sort_pos),
		.rd_idx (sort_idx)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_take && s_axis_tlast) begin
					state_d = (count_new >= CNTW'(2)) ? ST_CUR_RD : ST_FINISH;
				end
			end
			ST_CUR_RD:  state_d = ST_CUR_CAP;
			ST_CUR_CAP: state_d = ST_OTH_RD;
			ST_OTH_RD:  state_d = ST_OTH_CMP;
			ST_OTH_CMP: begin
				if (!(hit && pend_valid_q && !out_free)) begin
					if (k_next < CNTW'(i_q)) begin
						state_d = ST_OTH_RD;
					end else if (i_next < count_q) begin
						state_d = ST_CUR_RD;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		ram_rd_en     = 1'b0;
		sort_pos      = k_q;
		unique case (state_q)
			ST_LOAD:   s_axis_tready = 1'b1;
			ST_CUR_RD: begin
				ram_rd_en = 1'b1;
				sort_pos  = i_q;
			end
			ST_OTH_RD: ram_rd_en = 1'b1;
			ST_CUR_CAP, ST_OTH_CMP, ST_FINISH: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			margin_q     <= MARGIN_RESET;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			i_q          <= '0;
			k_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				margin_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_take) begin
						count_q <= count_new;
						if (!store) begin
							dropped_q <= 1'b1;
						end
						i_q <= IDXW'(1);
						k_q <= '0;
					end
				end
				ST_OTH_CMP: begin
					if (!(hit && pend_valid_q && !out_free)) begin
						if (hit) begin
							// The held pair is not the final one: it goes out now.
							pend_valid_q <= 1'b1;
						end
						if (k_next < CNTW'(i_q)) begin
							k_q <= k_next[IDXW-1:0];
						end else begin
							k_q <= '0;
							i_q <= i_next[IDXW-1:0];
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						count_q      <= '0;
						dropped_q    <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_CUR_RD, ST_CUR_CAP, ST_OTH_RD: ;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_CUR_CAP) begin
			cur_q <= rd_box;
		end
		if ((state_q == ST_OTH_CMP) && hit && !(pend_valid_q && !out_free)) begin
			pend_first_q  <= cur_q.body;
			pend_second_q <= rd_box.body;
			if (pend_valid_q) begin
				out_first_q  <= pend_first_q;
				out_second_q <= pend_second_q;
				out_pair_q   <= 1'b1;
				out_last_q   <= 1'b0;
				out_ovf_q    <= dropped_q;
			end
		end
		if ((state_q == ST_FINISH) && out_free) begin
			// With no pair in the set, an empty item with pair_valid low closes it.
			out_first_q  <= pend_valid_q ? pend_first_q : 16'd0;
			out_second_q <= pend_valid_q ? pend_second_q : 16'd0;
			out_pair_q   <= pend_valid_q;
			out_last_q   <= 1'b1;
			out_ovf_q    <= dropped_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_second_q, out_first_q};
	assign m_axis_tuser  = {out_ovf_q, out_pair_q};
	assign m_axis_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_sweep_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CUR_RD) |-> (count_q >= CNTW'(2)) && (i_next <= count_q))
		else $error("sweep started on fewer than two entries");

	a_k_below_i: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OTH_RD) || (state_q == ST_OTH_CMP)) |-> (k_q < i_q))
		else $error("inner index reached outer index");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> out_valid_q && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("waiting result overwritten");

	a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !store)
		else $error("box stored during sweep");

endmodule

// ===== tb/sv/sweep_prune_pair_finder_top_tb.sv =====
// Testbench of the sweep-and-prune pair finder: random and directed box sets, pairs checked.
`timescale 1ns / 1ps

module sweep_prune_pair_finder_top_tb;
	import spp_pkg::*;

	localparam int NMAX = MAX_ENTRIES_DEF;

	typedef struct {
		logic [15:0] first_body;
		logic [15:0] second_body;
		logic        pair_valid;
		logic        last_pair;
		logic        overflow;
	} pair_t;

	// Keeps its own copy of the margin and the stored set, and queues the pairs
	// that each closing box is expected to release.
	class pair_scoreboard;
		logic [15:0] margin;
		box_t        boxes[NMAX];
		int          count;
		bit          dropped;
		pair_t       pending[$];
		int          errors;

		function void clear();
			margin = MARGIN_RESET;
			count = 0;
			dropped = 0;
			errors = 0;
			pending.delete();
		endfunction

		function logic signed [31:0] lower(logic signed [31:0] v);
			longint d;
			d = longint'(v) - longint'(margin);
			if (d < -64'sd2147483648) d = -64'sd2147483648;
			return d[31:0];
		endfunction

		function logic signed [31:0] raise(logic signed [31:0] v);
			longint d;
			d = longint'(v) + longint'(margin);
			if (d > 64'sd2147483647) d = 64'sd2147483647;
			return d[31:0];
		endfunction

		function bit hits(box_t c, box_t o);
			if (o.max_x < c.min_x) return 0;
			if (c.body == o.body) return 0;
			if (c.is_static && o.is_static) return 0;
			if (c.sleeping && o.sleeping) return 0;
			if (c.group != 0 && c.group == o.group) return 0;
			if (c.max_y < o.min_y || c.min_y > o.max_y) return 0;
			if (c.max_z < o.min_z || c.min_z > o.max_z) return 0;
			return 1;
		endfunction

		// Note one accepted box; a closing box sorts and sweeps the stored set.
		function void note_box(logic [231:0] d, logic closing);
			box_t b;
			int order[NMAX];
			int i, j, key, found;
			pair_t p;
			if (count < NMAX) begin
				b.body = d[15:0];
				b.min_x = lower(d[47:16]);
				b.max_x = raise(d[79:48]);
				b.min_y = lower(d[111:80]);
				b.max_y = raise(d[143:112]);
				b.min_z = lower(d[175:144]);
				b.max_z = raise(d[207:176]);
				b.is_static = d[208];
				b.sleeping = d[209];
				b.group = d[225:210];
				boxes[count] = b;
				count++;
			end else begin
				dropped = 1;
			end
			if (!closing) return;
			// Insertion sort keeps equal keys in arrival order.
			for (i = 0; i < count; i++) order[i] = i;
			for (i = 1; i < count; i++) begin
				key = order[i];
				j = i;
				while (j > 0 && boxes[order[j-1]].min_x > boxes[key].min_x) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = key;
			end
			found = 0;
			for (i = 1; i < count; i++) begin
				for (j = 0; j < i; j++) begin
					if (hits(boxes[order[i]], boxes[order[j]])) begin
						p.first_body = boxes[order[i]].body;
						p.second_body = boxes[order[j]].body;
						p.pair_valid = 1;
						p.last_pair = 0;
						p.overflow = dropped;
						pending.insert(pending.size(), p);
						found++;
					end
				end
			end
			if (found == 0) begin
				p.first_body = 0;
				p.second_body = 0;
				p.pair_valid = 0;
				p.last_pair = 1;
				p.overflow = dropped;
				pending.insert(pending.size(), p);
			end else begin
				pending[pending.size()-1].last_pair = 1;
			end
			count = 0;
			dropped = 0;
		endfunction

		// Compare one accepted result with the oldest expected pair.
		function void check_pair(logic [31:0] d, logic [1:0] u, logic l);
			pair_t e;
			if (pending.size() == 0) begin
				$error("unexpected result first_body=%0d second_body=%0d", d[15:0], d[31:16]);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[15:0] !== e.first_body) begin
				$error("first_body: expected %0d, got %0d", e.first_body, d[15:0]);
				errors++;
			end
			if (d[31:16] !== e.second_body) begin
				$error("second_body: expected %0d, got %0d", e.second_body, d[31:16]);
				errors++;
			end
			if (u[0] !== e.pair_valid) begin
				$error("pair_valid: expected %0d, got %0d", e.pair_valid, u[0]);
				errors++;
			end
			if (u[1] !== e.overflow) begin
				$error("overflow: expected %0d, got %0d", e.overflow, u[1]);
				errors++;
			end
			if (l !== e.last_pair) begin
				$error("last_pair: expected %0d, got %0d", e.last_pair, l);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [231:0] s_axis_tdata = '0;
	logic         s_axis_tlast = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [31:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;

	pair_scoreboard pairs = new();

	// Idle percentages for the two sides; hold_off forces a long receiver stall.
	int  send_idle = 0;
	int  recv_stall = 0;
	int  hold_off = 0;
	longint cycles = 0;
	// Drift of a set's coordinates, so boxes near each other overlap often.
	int  spread_shift = 16;

	always #5 clk = ~clk;

	sweep_prune_pair_finder_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// The receiver decides its ready for the next edge at each rising edge. A
	// long hold-off counts down here while the sender keeps offering boxes.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			pairs.check_pair(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Timeout watch: the slowest correct run is far below this count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Write the margin register; only called while the block is idle.
	task automatic write_margin(input logic [15:0] m);
		cfg_valid <= 1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		pairs.margin = m;
	endtask

	// Offer one box and wait for it to be taken; the scoreboard notes it at acceptance.
	// The valid stays up after acceptance and is dropped by the next idle cycle or by drain.
	task automatic send_box(input logic [231:0] d, input logic closing);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		s_axis_tlast <= closing;
		do @(posedge clk); while (!s_axis_tready);
		pairs.note_box(d, closing);
	endtask

	function automatic logic [231:0] pack_box(logic [15:0] body,
			logic signed [31:0] x0, x1, y0, y1, z0, z1,
			logic st, logic sl, logic [15:0] grp);
		return {6'd0, grp, sl, st, z1, z0, y1, y0, x1, x0, body};
	endfunction

	// Random coordinate: mostly a small box near a set center, sometimes raw bits.
	function automatic logic signed [31:0] coord(int center, int offs);
		if ($urandom_range(19) == 0) return $urandom;
		return center + offs;
	endfunction

	function automatic logic [231:0] random_box(int cx, int cy, int cz);
		int dx, dy, dz, w;
		logic [15:0] grp;
		dx = $signed($urandom) >>> spread_shift;
		dy = $signed($urandom) >>> spread_shift;
		dz = $signed($urandom) >>> spread_shift;
		w = $urandom_range(1 << (32 - spread_shift));
		grp = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(2));
		return pack_box($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(9)),
			coord(cx, dx), coord(cx, dx + w), coord(cy, dy), coord(cy, dy + w),
			coord(cz, dz), coord(cz, dz + w),
			$urandom_range(3) == 0, $urandom_range(3) == 0, grp);
	endfunction

	// Send a set of n boxes, the last one closing it.
	task automatic random_set(input int n);
		int cx, cy, cz, i;
		cx = $urandom;
		cy = $urandom;
		cz = $urandom;
		for (i = 0; i < n; i++)
			send_box(random_box(cx, cy, cz), i == n - 1);
	endtask

	// Stop offering boxes, wait until all pairs have arrived, then let the sweep settle.
	task automatic drain();
		s_axis_tvalid <= 0;
		while (pairs.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	localparam logic signed [31:0] SMIN = 32'sh8000_0000;
	localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;

	initial begin
		int i, phase;
		pairs.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: a single box gives the empty result.
		send_box(pack_box(16'd1, 0, 100, 0, 100, 0, 100, 0, 0, 0), 1);
		// Saturation at both limits with the largest margin.
		drain();
		write_margin(16'hFFFF);
		send_box(pack_box(16'hFFFF, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 1, 1, 16'hFFFF), 0);
		send_box(pack_box(16'd0, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 0, 0, 16'd0), 0);
		send_box(pack_box(16'd2, 0, 0, 0, 0, 0, 0, 1, 1, 16'd5), 1);
		drain();
		write_margin(16'd0);
		// Touching edges, equal ids, both static, both sleeping, shared group, no group.
		send_box(pack_box(16'd10, 0, 10, 0, 10, 0, 10, 0, 0, 0), 0);
		send_box(pack_box(16'd11, 10, 20, 10, 20, 10, 20, 0, 0, 0), 0);
		send_box(pack_box(16'd10, 5, 8, 0, 10, 0, 10, 0, 0, 0), 0);
		send_box(pack_box(16'd12, 0, 10, 0, 10, 0, 10, 1, 0, 0), 0);
		send_box(pack_box(16'd13, 0, 10, 0, 10, 0, 10, 1, 0, 0), 0);
		send_box(pack_box(16'd14, 0, 10, 0, 10, 0, 10, 0, 1, 16'd3), 0);
		send_box(pack_box(16'd15, 0, 10, 0, 10, 0, 10, 0, 1, 16'd3), 0);
		send_box(pack_box(16'd16, 0, 10, 11, 12, 0, 10, 0, 0, 16'd3), 1);
		drain();
		// Overflow: ten boxes, the dropped closing box still starts the sweep.
		write_margin(MARGIN_RESET);
		for (i = 0; i < NMAX + 2; i++)
			send_box(pack_box(16'(i + 20), i, 40, 0, 5, 0, 5, 0, 0, 0), i == NMAX + 1);
		drain();
		// Overflow on a set with no pair at all.
		for (i = 0; i < NMAX + 1; i++)
			send_box(pack_box(16'd7, -i, 9, 0, 5, 0, 5, 0, 0, 0), i == NMAX);

		// Random phases with different idling and margin settings.
		for (phase = 0; phase < 8; phase++) begin
			drain();
			write_margin(phase == 7 ? 16'hFFFF : 16'($urandom));
			case (phase % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 55; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 55; end
				default: begin send_idle = 30; recv_stall = 30; end
			endcase
			spread_shift = (phase < 4) ? 16 : 8;
			if (phase == 2) hold_off = 400;
			for (i = 0; i < 6; i++)
				random_set($urandom_range(3) == 0 ? $urandom_range(9, NMAX + 2)
					: $urandom_range(1, NMAX));
		end

		// Wait for the last pairs, then a settling stretch.
		drain();
		repeat (200) @(posedge clk);
		if (pairs.errors == 0 && pairs.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
